// ===== sv/gwl_pkg.sv =====
// ----------------------------------------------------------------------------
// gwl_pkg
// Shared word types and constants for the greedy word-wrap line splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package gwl_pkg;

  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharSpace   = 8'd32;
  localparam logic [7:0] MinWidth    = 8'd4;
  localparam logic [7:0] ResetWidth  = 8'd20;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_mark;
  } in_word_t;

  typedef struct packed {
    logic [15:0] line_offset;
    logic [7:0]  line_length;
    logic        carries_line;
    logic        final_result;
  } out_word_t;

  // floor(v / 3) for 8-bit v by reciprocal multiply, exact below 512
  function automatic logic [7:0] div3(input logic [7:0] v);
    logic [16:0] prod;
    prod = {9'd0, v} * 17'd171;
    return prod[16:9];
  endfunction

endpackage

`default_nettype wire

// ===== sv/gwl_core.sv =====
// ----------------------------------------------------------------------------
// gwl_core
// Line state and single-pass wrap decision, one word per cycle with fire_i high.
// ----------------------------------------------------------------------------
`default_nettype none

module gwl_core import gwl_pkg::*; #(
  parameter int MAX_LINES = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire in_word_t   word_i,
  input  wire logic [7:0] line_width_i,
  output logic            res_emit_o,
  output out_word_t       res_word_o
);

  localparam int LinesW = $clog2(MAX_LINES + 1);

  logic [15:0]       text_position_q, text_position_d;
  logic [15:0]       chunk_begin_q, chunk_begin_d;
  logic [7:0]        chunk_count_q, chunk_count_d;
  logic [15:0]       space_offset_q, space_offset_d;
  logic              space_seen_q, space_seen_d;
  logic              line_has_text_q, line_has_text_d;
  logic [LinesW-1:0] lines_emitted_q, lines_emitted_d;

  always_comb begin
    logic [7:0]  w;
    logic [7:0]  w3;
    logic [15:0] pos_next;
    logic [15:0] diff_sp;
    logic [15:0] diff_tp;
    logic [7:0]  cc;
    logic        skip;
    logic        rec_carry;
    logic [15:0] rec_start;
    logic [7:0]  rec_len;
    logic        rec_fin;
    logic        room;
    logic        carry_eff;

    w        = (line_width_i < MinWidth) ? MinWidth : line_width_i;
    w3       = div3(w);
    pos_next = text_position_q + 16'd1;
    diff_sp  = space_offset_q - chunk_begin_q;
    diff_tp  = 16'd0;
    cc       = chunk_count_q;
    skip     = 1'b0;
    rec_carry = 1'b0;
    rec_start = 16'd0;
    rec_len   = 8'd0;
    rec_fin   = 1'b0;

    text_position_d = text_position_q;
    chunk_begin_d   = chunk_begin_q;
    chunk_count_d   = chunk_count_q;
    space_offset_d  = space_offset_q;
    space_seen_d    = space_seen_q;
    line_has_text_d = line_has_text_q;
    lines_emitted_d = lines_emitted_q;

    if (word_i.end_mark || word_i.char_code == CharNewline) begin
      rec_fin = word_i.end_mark;
      if (!line_has_text_q) begin
        rec_carry = 1'b1;
        rec_start = text_position_q;
      end else if (chunk_count_q != 8'd0) begin
        rec_carry = 1'b1;
        rec_start = chunk_begin_q;
        rec_len   = chunk_count_q;
      end
    end else begin
      if (chunk_count_q >= w) begin
        rec_carry = 1'b1;
        rec_start = chunk_begin_q;
        if (space_seen_q) begin
          rec_len       = diff_sp[7:0];
          chunk_begin_d = space_offset_q + 16'd1;
          diff_tp       = text_position_q - chunk_begin_d;
          cc            = diff_tp[7:0];
        end else begin
          rec_len       = chunk_count_q;
          chunk_begin_d = text_position_q;
          cc            = 8'd0;
          if (word_i.char_code == CharSpace) begin
            chunk_begin_d = pos_next;
            skip          = 1'b1;
          end
        end
        space_seen_d = 1'b0;
      end
    end

    room      = lines_emitted_q < LinesW'(MAX_LINES);
    carry_eff = rec_carry && room;
    if (carry_eff) begin
      lines_emitted_d = lines_emitted_q + LinesW'(1);
    end
    res_emit_o              = carry_eff || rec_fin;
    res_word_o.line_offset  = carry_eff ? rec_start : 16'd0;
    res_word_o.line_length  = carry_eff ? rec_len : 8'd0;
    res_word_o.carries_line = carry_eff;
    res_word_o.final_result = rec_fin;

    if (word_i.end_mark) begin
      text_position_d = 16'd0;
      chunk_begin_d   = 16'd0;
      chunk_count_d   = 8'd0;
      space_offset_d  = 16'd0;
      space_seen_d    = 1'b0;
      line_has_text_d = 1'b0;
      lines_emitted_d = '0;
    end else if (word_i.char_code == CharNewline) begin
      text_position_d = pos_next;
      chunk_begin_d   = pos_next;
      chunk_count_d   = 8'd0;
      space_seen_d    = 1'b0;
      line_has_text_d = 1'b0;
    end else begin
      line_has_text_d = 1'b1;
      if (!skip) begin
        if (word_i.char_code == CharSpace && cc >= w3 && cc < w) begin
          space_offset_d = text_position_q;
          space_seen_d   = 1'b1;
        end
        if (cc != 8'd255) begin
          cc = cc + 8'd1;
        end
      end
      chunk_count_d   = cc;
      text_position_d = pos_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_position_q <= 16'd0;
      chunk_begin_q   <= 16'd0;
      chunk_count_q   <= 8'd0;
      space_offset_q  <= 16'd0;
      space_seen_q    <= 1'b0;
      line_has_text_q <= 1'b0;
      lines_emitted_q <= '0;
    end else if (fire_i) begin
      text_position_q <= text_position_d;
      chunk_begin_q   <= chunk_begin_d;
      chunk_count_q   <= chunk_count_d;
      space_offset_q  <= space_offset_d;
      space_seen_q    <= space_seen_d;
      line_has_text_q <= line_has_text_d;
      lines_emitted_q <= lines_emitted_d;
    end
  end

  a_lines_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lines_emitted_q <= LinesW'(MAX_LINES))
    else $error("line count beyond limit");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && word_i.end_mark |=> text_position_q == 16'd0 && lines_emitted_q == '0)
    else $error("end word did not clear text state");

  a_empty_line_no_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !line_has_text_q |-> chunk_count_q == 8'd0)
    else $error("empty line holds chunk characters");

endmodule

`default_nettype wire

// ===== sv/greedy_word_wrap_line_splitter.sv =====
// ----------------------------------------------------------------------------
// greedy_word_wrap_line_splitter
// Splits a character stream into wrapped-line (offset, length) records.
// ----------------------------------------------------------------------------
// Each word passes the input reg and then the result reg; the result is
// registered. Throughput: one word per cycle while the result register is
// not stalled; the wrap decision is one pass of logic.
// A word waits in the input register only while the result register is full
// and stalled. Reset clears all text state and sets line_width to 20.
`default_nettype none

module greedy_word_wrap_line_splitter import gwl_pkg::*; #(
  parameter int MAX_LINES = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_word_t   in_word_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_word_t       out_word_o
);

  logic [7:0] line_width_q;
  logic       s1_valid_q, s1_valid_d;
  in_word_t   s1_word_q;
  logic       out_valid_q, out_valid_d;
  out_word_t  out_word_q;
  logic       out_ready;
  logic       core_fire;
  logic       in_fire;
  logic       res_emit;
  out_word_t  res_word;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign core_fire  = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  gwl_core #(
    .MAX_LINES(MAX_LINES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (core_fire),
    .word_i      (s1_word_q),
    .line_width_i(line_width_q),
    .res_emit_o  (res_emit),
    .res_word_o  (res_word)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (core_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (core_fire) begin
      out_valid_d = res_emit;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= ResetWidth;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        line_width_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q <= in_word_i;
    end
    if (core_fire && res_emit) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with nothing held");

  a_end_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_fire && s1_word_q.end_mark |=> out_valid_o && out_word_o.final_result)
    else $error("end word gave no final result");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.carries_line |->
      out_word_o.line_offset == 16'd0 && out_word_o.line_length == 8'd0)
    else $error("result without record has nonzero fields");

endmodule

`default_nettype wire
